// ===== rtl/core/uhm_pkg.sv =====
package uhm_pkg;

    localparam int ControlPacketSize   = 8;
    localparam int InterruptPacketSize = 8;
    localparam int RomSize             = 164;

    localparam logic [3:0] CMD_SETUP   = 4'd0;
    localparam logic [3:0] CMD_EP0_IN  = 4'd1;
    localparam logic [3:0] CMD_EP0_OUT = 4'd2;
    localparam logic [3:0] CMD_EP1_IN  = 4'd3;
    localparam logic [3:0] CMD_RESET   = 4'd4;
    localparam logic [3:0] CMD_PRESS   = 4'd5;
    localparam logic [3:0] CMD_RELEASE = 4'd6;
    localparam logic [3:0] CMD_MOVE    = 4'd7;
    localparam logic [3:0] CMD_SCROLL  = 4'd8;

    localparam logic [1:0] HS_ACK   = 2'd0;
    localparam logic [1:0] HS_NAK   = 2'd1;
    localparam logic [1:0] HS_STALL = 2'd2;
    localparam logic [1:0] HS_KEEP  = 2'd3;

    localparam logic [1:0] TG_NONE = 2'd0;
    localparam logic [1:0] TG_D1   = 2'd1;
    localparam logic [1:0] TG_D0   = 2'd2;

    localparam logic [7:0] OFS_DEV  = 8'd0;
    localparam logic [7:0] OFS_CFG  = 8'd18;
    localparam logic [7:0] OFS_RPT  = 8'd52;
    localparam logic [7:0] OFS_LANG = 8'd104;
    localparam logic [7:0] OFS_VEND = 8'd108;
    localparam logic [7:0] OFS_PROD = 8'd122;
    localparam logic [7:0] OFS_SER  = 8'd142;

    // descriptor byte at address a; packet sizes patched in by the caller
    function automatic logic [7:0] rom_byte(input logic [7:0] a, input logic [7:0] cps,
                                            input logic [7:0] ips);
        logic [7:0] v;
        v = 8'h00;
        case (a)
            8'd0: v = 8'd18;   8'd1: v = 8'h01;   8'd2: v = 8'h10;   8'd3: v = 8'h01;
            8'd4: v = 8'h00;   8'd5: v = 8'h00;   8'd6: v = 8'h00;   8'd7: v = cps;
            8'd8: v = 8'h86;   8'd9: v = 8'h1A;   8'd10: v = 8'h0C;  8'd11: v = 8'hFE;
            8'd12: v = 8'h00;  8'd13: v = 8'h01;  8'd14: v = 8'h01;  8'd15: v = 8'h02;
            8'd16: v = 8'h03;  8'd17: v = 8'h01;
            8'd18: v = 8'h09;  8'd19: v = 8'h02;  8'd20: v = 8'd34;  8'd21: v = 8'd0;
            8'd22: v = 8'h01;  8'd23: v = 8'h01;  8'd24: v = 8'h00;  8'd25: v = 8'h80;
            8'd26: v = 8'h32;
            8'd27: v = 8'h09;  8'd28: v = 8'h04;  8'd29: v = 8'h00;  8'd30: v = 8'h00;
            8'd31: v = 8'h01;  8'd32: v = 8'h03;  8'd33: v = 8'h01;  8'd34: v = 8'h02;
            8'd35: v = 8'h04;
            8'd36: v = 8'h09;  8'd37: v = 8'h21;  8'd38: v = 8'h10;  8'd39: v = 8'h01;
            8'd40: v = 8'h00;  8'd41: v = 8'h01;  8'd42: v = 8'h22;  8'd43: v = 8'd52;
            8'd44: v = 8'd0;
            8'd45: v = 8'h07;  8'd46: v = 8'h05;  8'd47: v = 8'h81;  8'd48: v = 8'h03;
            8'd49: v = ips;    8'd50: v = 8'h00;  8'd51: v = 8'h01;
            8'd52: v = 8'h05;  8'd53: v = 8'h01;  8'd54: v = 8'h09;  8'd55: v = 8'h02;
            8'd56: v = 8'hA1;  8'd57: v = 8'h01;  8'd58: v = 8'h09;  8'd59: v = 8'h01;
            8'd60: v = 8'hA1;  8'd61: v = 8'h00;  8'd62: v = 8'h05;  8'd63: v = 8'h09;
            8'd64: v = 8'h19;  8'd65: v = 8'h01;  8'd66: v = 8'h29;  8'd67: v = 8'h03;
            8'd68: v = 8'h15;  8'd69: v = 8'h00;  8'd70: v = 8'h25;  8'd71: v = 8'h01;
            8'd72: v = 8'h75;  8'd73: v = 8'h01;  8'd74: v = 8'h95;  8'd75: v = 8'h03;
            8'd76: v = 8'h81;  8'd77: v = 8'h02;  8'd78: v = 8'h75;  8'd79: v = 8'h05;
            8'd80: v = 8'h95;  8'd81: v = 8'h01;  8'd82: v = 8'h81;  8'd83: v = 8'h03;
            8'd84: v = 8'h05;  8'd85: v = 8'h01;  8'd86: v = 8'h09;  8'd87: v = 8'h30;
            8'd88: v = 8'h09;  8'd89: v = 8'h31;  8'd90: v = 8'h09;  8'd91: v = 8'h38;
            8'd92: v = 8'h15;  8'd93: v = 8'h81;  8'd94: v = 8'h25;  8'd95: v = 8'h7F;
            8'd96: v = 8'h75;  8'd97: v = 8'h08;  8'd98: v = 8'h95;  8'd99: v = 8'h03;
            8'd100: v = 8'h81; 8'd101: v = 8'h06; 8'd102: v = 8'hC0; 8'd103: v = 8'hC0;
            8'd104: v = 8'h04; 8'd105: v = 8'h03; 8'd106: v = 8'h09; 8'd107: v = 8'h04;
            8'd108: v = 8'd14; 8'd109: v = 8'h03; 8'd110: v = 8'h77; 8'd112: v = 8'h63;
            8'd114: v = 8'h68; 8'd116: v = 8'h2E; 8'd118: v = 8'h63; 8'd120: v = 8'h6E;
            8'd122: v = 8'd20; 8'd123: v = 8'h03; 8'd124: v = 8'h55; 8'd126: v = 8'h53;
            8'd128: v = 8'h42; 8'd130: v = 8'h20; 8'd132: v = 8'h4D; 8'd134: v = 8'h6F;
            8'd136: v = 8'h75; 8'd138: v = 8'h73; 8'd140: v = 8'h65;
            8'd142: v = 8'd22; 8'd143: v = 8'h03; 8'd144: v = 8'h44; 8'd146: v = 8'h45;
            8'd148: v = 8'h41; 8'd150: v = 8'h44; 8'd152: v = 8'h42; 8'd154: v = 8'h45;
            8'd156: v = 8'h45; 8'd158: v = 8'h46; 8'd160: v = 8'h30; 8'd162: v = 8'h32;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/uhm_rom.sv =====
module uhm_rom
    import uhm_pkg::*;
#(
    parameter int CONTROL_PACKET_SIZE   = ControlPacketSize,
    parameter int INTERRUPT_PACKET_SIZE = InterruptPacketSize
)
(
    input  logic       clk,
    input  logic [7:0] addr,
    output logic [7:0] rdata
);

    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        rdata_reg <= rom_byte(addr, 8'(CONTROL_PACKET_SIZE), 8'(INTERRUPT_PACKET_SIZE));
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/usb_hid_mouse_control_responder.sv =====
// Channel   Direction  Handshake        Fields
// command   in         start / busy     cmd, request_*, button_mask, *_delta
// response  out        strobe (1 cycle) endpoint .. last
//
// Results go out one per cycle, except descriptor bytes. A command is first decoded in
// ST_DECODE, then emits its results (one per data byte, up to CONTROL_PACKET_SIZE bytes
// capped at 64); a descriptor byte waits in ST_READ for the synchronous ROM read
// before ST_BYTE emits it. busy drops in the cycle that carries the final strobe.
// Asynchronous active-low reset clears the control state and the report.
// The receiver cannot stall: results go out at the strobe unconditionally.
module usb_hid_mouse_control_responder
    import uhm_pkg::*;
#(
    parameter int CONTROL_PACKET_SIZE   = ControlPacketSize,
    parameter int INTERRUPT_PACKET_SIZE = InterruptPacketSize
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  cmd,
    input  logic [7:0]  request_type,
    input  logic [7:0]  request_code,
    input  logic [15:0] request_value,
    input  logic [15:0] request_index,
    input  logic [15:0] request_length,
    input  logic [7:0]  button_mask,
    input  logic [7:0]  x_delta,
    input  logic [7:0]  y_delta,
    input  logic [7:0]  wheel_delta,
    output logic        strobe,
    output logic        endpoint,
    output logic [6:0]  tx_length,
    output logic [7:0]  data_byte,
    output logic        byte_valid,
    output logic [1:0]  in_handshake,
    output logic [1:0]  out_handshake,
    output logic [1:0]  toggle_reset,
    output logic [6:0]  new_address,
    output logic        address_apply,
    output logic        last
);

    localparam int ChunkMax = (CONTROL_PACKET_SIZE > 64) ? 64 : CONTROL_PACKET_SIZE;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_ONE    = 5'b00100,
        ST_READ   = 5'b01000,
        ST_BYTE   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  cmd_reg;
    logic [7:0]  rtype_in_reg, code_in_reg, mask_reg, xd_reg, yd_reg, wd_reg;
    logic [15:0] value_reg, index_reg, wlen_reg;

    logic [7:0]  saved_type_reg, saved_code_reg;
    logic [15:0] remaining_reg;
    logic [7:0]  dptr_reg;
    logic        dactive_reg;
    logic [6:0]  paddr_reg;
    logic [7:0]  config_reg, idle_reg, proto_reg;
    logic [7:0]  rpt_reg [4];
    logic        rpt_pending_reg;

    // packet sequencer
    logic [6:0]  len_reg;
    logic [6:0]  cnt_reg;
    logic        from_rom_reg;
    logic [7:0]  small_reg [4];
    logic [1:0]  inh_reg, outh_reg, tog_reg;
    logic        ep_reg;
    logic        second_reg;   // ep0 status after ep1 feature, or reset second result

    logic [7:0]  rom_data;
    logic [7:0]  rom_addr;

    uhm_rom #(
        .CONTROL_PACKET_SIZE  (CONTROL_PACKET_SIZE),
        .INTERRUPT_PACKET_SIZE(INTERRUPT_PACKET_SIZE)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .rdata(rom_data)
    );

    assign rom_addr = dptr_reg;
    assign busy = (state_reg != ST_IDLE);

    // output registers
    logic        strobe_reg, ep_o_reg, bv_reg, apply_reg, last_reg;
    logic [6:0]  txl_reg, naddr_reg;
    logic [7:0]  db_reg;
    logic [1:0]  inh_o_reg, outh_o_reg, tog_o_reg;

    assign strobe = strobe_reg;
    assign endpoint = ep_o_reg;
    assign tx_length = txl_reg;
    assign data_byte = db_reg;
    assign byte_valid = bv_reg;
    assign in_handshake = inh_o_reg;
    assign out_handshake = outh_o_reg;
    assign toggle_reset = tog_o_reg;
    assign new_address = naddr_reg;
    assign address_apply = apply_reg;
    assign last = last_reg;

    // setup decode
    logic        d_stall, d_rom, d_feat;
    logic [7:0]  d_ofs;
    logic [6:0]  d_len;
    logic [1:0]  d_f_in, d_f_out;
    always_comb
    begin
        d_stall = 1'b0;
        d_rom = 1'b0;
        d_feat = 1'b0;
        d_ofs = OFS_DEV;
        d_len = 7'd0;
        d_f_in = HS_KEEP;
        d_f_out = HS_KEEP;
        if (rtype_in_reg[6:5] == 2'b00)
        begin
            case (code_in_reg)
                8'h00: d_len = 7'd2;
                8'h01:
                begin
                    if (rtype_in_reg[4:0] != 5'h02) d_stall = 1'b1;
                    else if (index_reg[7:0] == 8'h01)
                    begin
                        d_feat = 1'b1; d_f_out = HS_ACK;
                    end
                    else if (index_reg[7:0] == 8'h81)
                    begin
                        d_feat = 1'b1; d_f_in = HS_NAK;
                    end
                    else d_stall = 1'b1;
                end
                8'h03:
                begin
                    if (rtype_in_reg[4:0] != 5'h02 || index_reg[15:8] != 8'h00) d_stall = 1'b1;
                    else if (index_reg[7:0] == 8'h01)
                    begin
                        d_feat = 1'b1; d_f_out = HS_STALL;
                    end
                    else if (index_reg[7:0] == 8'h81)
                    begin
                        d_feat = 1'b1; d_f_in = HS_STALL;
                    end
                    else d_stall = 1'b1;
                end
                8'h05: d_len = 7'd0;
                8'h06:
                begin
                    case (value_reg[15:8])
                        8'h01:
                        begin
                            d_rom = 1'b1; d_ofs = OFS_DEV; d_len = 7'd18;
                        end
                        8'h02:
                        begin
                            d_rom = 1'b1; d_ofs = OFS_CFG; d_len = 7'd34;
                        end
                        8'h03:
                        begin
                            d_rom = 1'b1;
                            case (value_reg[7:0])
                                8'd0:
                                begin
                                    d_ofs = OFS_LANG; d_len = 7'd4;
                                end
                                8'd1:
                                begin
                                    d_ofs = OFS_VEND; d_len = 7'd14;
                                end
                                8'd2, 8'd4:
                                begin
                                    d_ofs = OFS_PROD; d_len = 7'd20;
                                end
                                default:
                                begin
                                    d_ofs = OFS_SER; d_len = 7'd22;
                                end
                            endcase
                        end
                        8'h22:
                        begin
                            if (value_reg[7:0] == 8'h00)
                            begin
                                d_rom = 1'b1; d_ofs = OFS_RPT; d_len = 7'd52;
                            end
                            else d_stall = 1'b1;
                        end
                        default: d_stall = 1'b1;
                    endcase
                end
                8'h08, 8'h0A: d_len = 7'd1;
                8'h09, 8'h0B: d_len = 7'd0;
                default: d_stall = 1'b1;
            endcase
        end
        else if (rtype_in_reg[6:5] == 2'b01)
        begin
            case (code_in_reg)
                8'h01: d_len = 7'd4;
                8'h02, 8'h03: d_len = 7'd1;
                8'h09, 8'h0A, 8'h0B: d_len = 7'd0;
                default: d_stall = 1'b1;
            endcase
        end
        else
        begin
            d_stall = 1'b1;
        end
    end

    logic [15:0] setup_rem;
    logic [6:0]  setup_chunk;
    logic [15:0] in_chunk_w;
    always_comb
    begin
        setup_rem = (wlen_reg > {9'd0, d_len}) ? {9'd0, d_len} : wlen_reg;
        setup_chunk = (setup_rem > 16'(ChunkMax)) ? 7'(ChunkMax) : setup_rem[6:0];
        in_chunk_w = (remaining_reg > 16'(ChunkMax)) ? 16'(ChunkMax) : remaining_reg;
    end

    logic is_desc;
    assign is_desc = (saved_type_reg[6:5] == 2'b00) && (saved_code_reg == 8'h06);

    logic [7:0] cur_byte;
    always_comb
    begin
        if (from_rom_reg)
            cur_byte = (dactive_reg && dptr_reg < 8'(RomSize)) ? rom_data : 8'h00;
        else
            cur_byte = (cnt_reg < 7'd4) ? small_reg[cnt_reg[1:0]] : 8'h00;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start) state_next = ST_DECODE;
            default:   state_next = state_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            saved_type_reg <= '0;
            saved_code_reg <= '0;
            remaining_reg <= '0;
            dptr_reg <= '0;
            dactive_reg <= 1'b0;
            paddr_reg <= '0;
            config_reg <= '0;
            idle_reg <= '0;
            proto_reg <= 8'h01;
            rpt_reg <= '{default: 8'h00};
            rpt_pending_reg <= 1'b0;
            strobe_reg <= 1'b0;
            second_reg <= 1'b0;
            len_reg <= '0;
            cnt_reg <= '0;
            from_rom_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    state_reg <= state_next;
                end
                ST_DECODE:
                begin
                    state_reg <= ST_ONE;
                    second_reg <= 1'b0;
                    len_reg <= 7'd0;
                    cnt_reg <= 7'd0;
                    from_rom_reg <= 1'b0;
                    ep_reg <= 1'b0;
                    inh_reg <= HS_KEEP;
                    outh_reg <= HS_KEEP;
                    tog_reg <= TG_NONE;
                    small_reg <= '{default: 8'h00};
                    naddr_reg <= 7'd0;
                    apply_reg <= 1'b0;
                    case (cmd_reg)
                        CMD_SETUP:
                        begin
                            saved_type_reg <= rtype_in_reg;
                            saved_code_reg <= d_stall ? 8'hFF : code_in_reg;
                            dactive_reg <= d_rom && !d_stall;
                            dptr_reg <= (d_rom && !d_stall) ? d_ofs : 8'd0;
                            if (d_stall)
                            begin
                                remaining_reg <= wlen_reg;
                                inh_reg <= HS_STALL; outh_reg <= HS_STALL; tog_reg <= TG_D1;
                            end
                            else
                            begin
                                remaining_reg <= setup_rem - {9'd0, setup_chunk};
                                len_reg <= setup_chunk;
                                from_rom_reg <= d_rom;
                                inh_reg <= HS_ACK; outh_reg <= HS_ACK; tog_reg <= TG_D1;
                                if (d_rom && setup_chunk != 7'd0) state_reg <= ST_READ;
                                if (rtype_in_reg[6:5] == 2'b00)
                                begin
                                    case (code_in_reg)
                                        8'h05: paddr_reg <= value_reg[6:0];
                                        8'h08: small_reg[0] <= config_reg;
                                        8'h09: config_reg <= value_reg[7:0];
                                        default: ;
                                    endcase
                                end
                                else
                                begin
                                    case (code_in_reg)
                                        8'h01: small_reg <= rpt_reg;
                                        8'h02: small_reg[0] <= idle_reg;
                                        8'h03: small_reg[0] <= proto_reg;
                                        8'h0A: idle_reg <= value_reg[15:8];
                                        8'h0B: proto_reg <= value_reg[7:0];
                                        default: ;
                                    endcase
                                end
                            end
                            if (d_feat)
                            begin
                                // ep1 result first, ep0 status follows
                                second_reg <= 1'b1;
                                ep_reg <= 1'b1;
                                inh_reg <= d_f_in; outh_reg <= d_f_out; tog_reg <= TG_D0;
                                state_reg <= ST_ONE;
                            end
                        end
                        CMD_EP0_IN:
                        begin
                            if (is_desc)
                            begin
                                len_reg <= in_chunk_w[6:0];
                                remaining_reg <= remaining_reg - in_chunk_w;
                                from_rom_reg <= 1'b1;
                                inh_reg <= HS_ACK;
                                if (in_chunk_w != 16'd0) state_reg <= ST_READ;
                            end
                            else if (saved_type_reg[6:5] == 2'b00 && saved_code_reg == 8'h05)
                            begin
                                naddr_reg <= paddr_reg;
                                apply_reg <= 1'b1;
                            end
                        end
                        CMD_EP0_OUT:
                        begin
                            inh_reg <= HS_ACK; outh_reg <= HS_ACK; tog_reg <= TG_D1;
                        end
                        CMD_EP1_IN:
                        begin
                            rpt_reg[1] <= 8'h00; rpt_reg[2] <= 8'h00; rpt_reg[3] <= 8'h00;
                            rpt_pending_reg <= 1'b0;
                            ep_reg <= 1'b1;
                        end
                        CMD_RESET:
                        begin
                            rpt_reg <= '{default: 8'h00};
                            rpt_pending_reg <= 1'b0;
                            idle_reg <= 8'h00;
                            proto_reg <= 8'h01;
                            inh_reg <= HS_NAK; outh_reg <= HS_ACK; tog_reg <= TG_D0;
                            second_reg <= 1'b1;
                        end
                        CMD_PRESS, CMD_RELEASE, CMD_MOVE, CMD_SCROLL:
                        begin
                            small_reg <= rpt_reg;
                            if (cmd_reg == CMD_PRESS)
                            begin
                                rpt_reg[0] <= rpt_reg[0] | mask_reg;
                                small_reg[0] <= rpt_reg[0] | mask_reg;
                            end
                            else if (cmd_reg == CMD_RELEASE)
                            begin
                                rpt_reg[0] <= rpt_reg[0] & ~mask_reg;
                                small_reg[0] <= rpt_reg[0] & ~mask_reg;
                            end
                            else if (cmd_reg == CMD_MOVE)
                            begin
                                rpt_reg[1] <= rpt_reg[1] + xd_reg;
                                rpt_reg[2] <= rpt_reg[2] + yd_reg;
                                small_reg[1] <= rpt_reg[1] + xd_reg;
                                small_reg[2] <= rpt_reg[2] + yd_reg;
                            end
                            else
                            begin
                                rpt_reg[3] <= rpt_reg[3] + wd_reg;
                                small_reg[3] <= rpt_reg[3] + wd_reg;
                            end
                            rpt_pending_reg <= 1'b1;
                            ep_reg <= 1'b1;
                            len_reg <= 7'd4;
                            inh_reg <= HS_ACK;
                        end
                        default: state_reg <= ST_IDLE;
                    endcase
                end
                ST_READ:
                begin
                    // ROM data for dptr_reg is valid next cycle
                    state_reg <= ST_BYTE;
                end
                ST_ONE, ST_BYTE:
                begin
                    strobe_reg <= 1'b1;
                    ep_o_reg <= ep_reg;
                    txl_reg <= len_reg;
                    inh_o_reg <= inh_reg;
                    outh_o_reg <= outh_reg;
                    tog_o_reg <= tog_reg;
                    if (len_reg == 7'd0)
                    begin
                        db_reg <= 8'h00;
                        bv_reg <= 1'b0;
                        last_reg <= !second_reg;
                        if (second_reg)
                        begin
                            second_reg <= 1'b0;
                            if (cmd_reg == CMD_RESET)
                                ep_reg <= 1'b1;
                            else
                            begin
                                // ep0 status stage of a feature request
                                ep_reg <= 1'b0;
                                inh_reg <= HS_ACK; outh_reg <= HS_ACK; tog_reg <= TG_D1;
                            end
                        end
                        else
                            state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        db_reg <= cur_byte;
                        bv_reg <= 1'b1;
                        last_reg <= (cnt_reg == len_reg - 7'd1);
                        cnt_reg <= cnt_reg + 7'd1;
                        if (from_rom_reg)
                        begin
                            dptr_reg <= dptr_reg + 8'd1;
                            state_reg <= ST_READ;
                        end
                        if (cnt_reg == len_reg - 7'd1)
                            state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
            rtype_in_reg <= request_type;
            code_in_reg <= request_code;
            value_reg <= request_value;
            index_reg <= request_index;
            wlen_reg <= request_length;
            mask_reg <= button_mask;
            xd_reg <= x_delta;
            yd_reg <= y_delta;
            wd_reg <= wheel_delta;
        end
    end

endmodule
